// ===== rtl/priority_ip_range_classifier_core_assert.svh =====
// Assertion macros for the priority IP range classifier.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PRIORITY_IP_RANGE_CLASSIFIER_CORE_ASSERT_SVH
`define PRIORITY_IP_RANGE_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define PIRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pirc_pkg.sv =====
// Package for the priority IP range classifier: item kinds, rule types,
// verdict codes, sequencer states. No dependencies.
`timescale 1ns / 1ps

package pirc_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RT_NORMAL = 2'd0,
    RT_WHITE  = 2'd1,
    RT_BLACK  = 2'd2,
    RT_OTHER  = 2'd3
  } rule_type_e;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_REDIRECT = 2'd1,
    VERDICT_REJECT   = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_CHK,
    S_RESP
  } state_e;

  localparam int unsigned CountOutBits = 7;

  function automatic verdict_e type_verdict(input logic [1:0] rtype);
    verdict_e v;
    case (rtype)
      RT_NORMAL: v = VERDICT_REDIRECT;
      RT_BLACK:  v = VERDICT_REJECT;
      default:   v = VERDICT_PASS;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pirc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pirc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrBits-1:0]  waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AddrBits-1:0]  raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/priority_ip_range_classifier_core.sv =====
// Check: an empty table goes straight to the response, else one RAM read per rule up to a hit.
// Insert: into a full table it only flags full; else one RAM read per compare, one write
// per rule moved down, then the new rule is written. Clear and unused kinds: no RAM access.
// One item at a time; in_stall_o is high while busy.
// Result waits in an output register; the next item is taken while it waits.
// Reset (rst_ni low, async) empties the table and drops any pending result.
`timescale 1ns / 1ps
`include "priority_ip_range_classifier_core_assert.svh"

module priority_ip_range_classifier_core
  import pirc_pkg::*;
#(
  parameter int unsigned MAX_RULES     = 64,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  rule_type_i,
  input  logic [15:0] rule_priority_i,
  input  logic        rule_enable_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic        matched_o,
  output logic        table_full_o,
  output logic [6:0]  rule_count_o
);

  localparam int unsigned AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CW = $clog2(MAX_RULES + 1);
  localparam int unsigned PB = PRIORITY_BITS;
  localparam int unsigned RW = 64 + PB + 3;
  // word layout: low bound, high bound, priority, enable, type
  localparam int unsigned LoMsb = RW - 1;
  localparam int unsigned HiMsb = RW - 33;
  localparam int unsigned PrMsb = PB + 2;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic          pend_q, pend_d;

  logic [1:0]    kind_q;
  logic [1:0]    type_q;
  logic [PB-1:0] prio_q;
  logic          en_q;
  logic [31:0]   lo_q, hi_q, addr_q;

  logic [1:0]    res_verdict_q, res_verdict_d;
  logic          res_matched_q, res_matched_d;
  logic          res_full_q, res_full_d;

  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_verdict_q;
  logic                    out_matched_q, out_full_q;
  logic [CountOutBits-1:0] out_count_q;
  logic                    out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic          in_xfer;
  logic [31:0]   prio_ext;
  logic [31:0]   count_ext;
  logic [31:0]   rd_lo, rd_hi;
  logic [PB-1:0] rd_prio;
  logic          rd_en;
  logic [1:0]    rd_type;
  logic          rd_hit;
  logic          issue;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign prio_ext  = 32'(rule_priority_i);
  assign count_ext = 32'(count_q);

  assign rd_lo   = ram_rdata[LoMsb -: 32];
  assign rd_hi   = ram_rdata[HiMsb -: 32];
  assign rd_prio = ram_rdata[PrMsb -: PB];
  assign rd_en   = ram_rdata[2];
  assign rd_type = ram_rdata[1:0];
  assign rd_hit  = rd_en && (addr_q > rd_lo) && (addr_q < rd_hi);
  assign issue   = ridx_q < count_q;

  pirc_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_RULES)
  ) u_rules (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    ridx_d        = ridx_q;
    pend_d        = 1'b0;
    res_verdict_d = res_verdict_q;
    res_matched_d = res_matched_q;
    res_full_d    = res_full_q;
    ram_we        = 1'b0;
    ram_waddr     = pos_q[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = ridx_q[AW-1:0];
    out_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_verdict_d = VERDICT_PASS;
          res_matched_d = 1'b0;
          res_full_d    = 1'b0;
          pos_d         = count_q;
          ridx_d        = '0;
          state_d       = S_RESP;
          case (kind_i)
            KIND_CLEAR: begin
              count_d = '0;
            end
            KIND_INSERT: begin
              if (count_q == CW'(MAX_RULES)) begin
                res_full_d = 1'b1;
              end else if (count_q == '0) begin
                state_d = S_INS_WR;
              end else begin
                state_d = S_INS_RD;
              end
            end
            KIND_CHECK: begin
              if (count_q != '0) begin
                state_d = S_CHK;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_INS_RD: begin
        ram_raddr = AW'(pos_q - 1'b1);
        state_d   = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rd_prio < prio_q) begin
          ram_we  = 1'b1;
          pos_d   = pos_q - 1'b1;
          state_d = (pos_q == CW'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {lo_q, hi_q, prio_q, en_q, type_q};
        count_d   = count_q + 1'b1;
        state_d   = S_RESP;
      end
      S_CHK: begin
        if (issue) begin
          ridx_d = ridx_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q && rd_hit) begin
          res_verdict_d = type_verdict(rd_type);
          res_matched_d = 1'b1;
          pend_d        = 1'b0;
          state_d       = S_RESP;
        end else if (!issue) begin
          pend_d  = 1'b0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && out_stall_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      ridx_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      ridx_q      <= ridx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_i;
      type_q <= rule_type_i;
      prio_q <= prio_ext[PB-1:0];
      en_q   <= rule_enable_i;
      lo_q   <= range_low_i;
      hi_q   <= range_high_i;
      addr_q <= address_i;
    end
    res_verdict_q <= res_verdict_d;
    res_matched_q <= res_matched_d;
    res_full_q    <= res_full_d;
    if (out_load) begin
      out_verdict_q <= res_verdict_q;
      out_matched_q <= res_matched_q;
      out_full_q    <= res_full_q;
      out_count_q   <= count_ext[CountOutBits-1:0];
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign verdict_o    = out_verdict_q;
  assign matched_o    = out_matched_q;
  assign table_full_o = out_full_q;
  assign rule_count_o = out_count_q;

  `PIRC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(MAX_RULES), "rule count above table size")
  `PIRC_ASSERT_IMPL(a_full_only_when_full, (state_q == S_RESP) && res_full_q && (kind_q == KIND_INSERT), count_q == CW'(MAX_RULES), "insert dropped with free space")
  `PIRC_ASSERT_NEXT(a_insert_counts, state_q == S_INS_WR, count_q == $past(count_q) + 1'b1, "insert did not bump rule count")
  `PIRC_ASSERT_IMPL(a_nomatch_pass, (state_q == S_RESP) && !res_matched_q, res_verdict_q == VERDICT_PASS, "verdict without match is not pass")

endmodule
